### rtl/huffman_code_builder_assert.svh
// Assertion macros used by the code builder sequencer RTL
`ifndef HUFFMAN_CODE_BUILDER_ASSERT_SVH
`define HUFFMAN_CODE_BUILDER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define HCB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked out of reset
`define HCB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/hcb_pkg.sv
// Types and constants shared by the code builder modules
`default_nettype none
package hcb_pkg;
    localparam int SYM_W    = 8;
    localparam int OP_W     = 2;
    localparam int WEIGHT_W = 40;
    localparam int CODE_W   = 64;
    localparam int LEN_W    = 6;
    localparam int LEAFO_W  = 9;

    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_BUILD = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

    localparam logic [LEN_W-1:0] LEN_MAX = 6'd63;

    typedef struct packed {
        logic                alive;
        logic [SYM_W-1:0]    sym;
        logic [WEIGHT_W-1:0] weight;
    } t_node;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } t_path;

    typedef struct packed {
        logic load;
        logic rd_issue;
        logic rd_out;
        logic build_init;
        logic leaf_wr;
        logic leaf_end;
        logic scan_step;
        logic take;
        logic merge;
        logic walk_init;
        logic walk_l;
        logic walk_r;
        logic emit_wr;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic few;
        logic leaf_last;
        logic scan_done;
        logic second;
        logic merge_last;
        logic walk_last;
        logic emit_last;
    } t_sts;
endpackage
`default_nettype wire

### rtl/hcb_ctrl.sv
// Sequencer for load, read and the build phases
`default_nettype none
module hcb_ctrl (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   start,
    input  wire logic [hcb_pkg::OP_W-1:0] i_op,
    input  wire hcb_pkg::t_sts          i_sts,
    output hcb_pkg::t_cmd               o_cmd,
    output logic                        busy
);
    import hcb_pkg::*;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_READ      = 4'd1;
    localparam logic [3:0] S_LEAF_RD   = 4'd2;
    localparam logic [3:0] S_LEAF_WR   = 4'd3;
    localparam logic [3:0] S_LEAF_END  = 4'd4;
    localparam logic [3:0] S_SCAN      = 4'd5;
    localparam logic [3:0] S_TAKE      = 4'd6;
    localparam logic [3:0] S_MERGE     = 4'd7;
    localparam logic [3:0] S_WALK_INIT = 4'd8;
    localparam logic [3:0] S_WALK_RD   = 4'd9;
    localparam logic [3:0] S_WALK_L    = 4'd10;
    localparam logic [3:0] S_WALK_R    = 4'd11;
    localparam logic [3:0] S_EMIT_RD   = 4'd12;
    localparam logic [3:0] S_EMIT_WR   = 4'd13;
    localparam logic [3:0] S_FINISH    = 4'd14;

    logic [3:0] r_state, n_state;
    logic       accept;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_op)
                        OP_LOAD: begin
                            o_cmd.load = 1'b1;
                        end
                        OP_BUILD: begin
                            o_cmd.build_init = 1'b1;
                            n_state = S_LEAF_RD;
                        end
                        OP_READ: begin
                            o_cmd.rd_issue = 1'b1;
                            n_state = S_READ;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                o_cmd.rd_out = 1'b1;
                n_state = S_IDLE;
            end
            S_LEAF_RD: begin
                n_state = S_LEAF_WR;
            end
            S_LEAF_WR: begin
                o_cmd.leaf_wr = 1'b1;
                n_state = i_sts.leaf_last ? S_LEAF_END : S_LEAF_RD;
            end
            S_LEAF_END: begin
                o_cmd.leaf_end = 1'b1;
                n_state = i_sts.few ? S_FINISH : S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_TAKE;
                end
            end
            S_TAKE: begin
                o_cmd.take = 1'b1;
                n_state = i_sts.second ? S_MERGE : S_SCAN;
            end
            S_MERGE: begin
                o_cmd.merge = 1'b1;
                n_state = i_sts.merge_last ? S_WALK_INIT : S_SCAN;
            end
            S_WALK_INIT: begin
                o_cmd.walk_init = 1'b1;
                n_state = S_WALK_RD;
            end
            S_WALK_RD: begin
                n_state = S_WALK_L;
            end
            S_WALK_L: begin
                o_cmd.walk_l = 1'b1;
                n_state = S_WALK_R;
            end
            S_WALK_R: begin
                o_cmd.walk_r = 1'b1;
                n_state = i_sts.walk_last ? S_EMIT_RD : S_WALK_RD;
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_WR;
            end
            S_EMIT_WR: begin
                o_cmd.emit_wr = 1'b1;
                n_state = i_sts.emit_last ? S_FINISH : S_EMIT_RD;
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `include "huffman_code_builder_assert.svh"

    // the second take toggles the pair flag back before the merge
    `HCB_ASSERT_NEXT(a_build_enters_leaves, accept && (i_op == OP_BUILD), r_state == S_LEAF_RD)
    `HCB_ASSERT_NOW(a_merge_has_pair, r_state == S_MERGE, !i_sts.second)
    `HCB_ASSERT_NEXT(a_walk_loops, (r_state == S_WALK_R) && !i_sts.walk_last,
                     r_state == S_WALK_RD)
    `HCB_ASSERT_NEXT(a_read_returns, r_state == S_READ, r_state == S_IDLE)
endmodule
`default_nettype wire

### rtl/hcb_datapath.sv
// Tables, node memory and tree arithmetic of the code builder
`default_nettype none
module hcb_datapath #(
    parameter int SYMBOLS    = 256,
    parameter int COUNT_BITS = 31
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire hcb_pkg::t_cmd                 i_cmd,
    output hcb_pkg::t_sts                      o_sts,
    input  wire logic [hcb_pkg::SYM_W-1:0]     i_symbol,
    input  wire logic [COUNT_BITS-1:0]         i_count,
    output logic                               o_strobe,
    output logic [hcb_pkg::SYM_W-1:0]          o_sym_out,
    output logic [hcb_pkg::LEN_W-1:0]          o_code_length,
    output logic [hcb_pkg::CODE_W-1:0]         o_code_bits,
    output logic [hcb_pkg::LEAFO_W-1:0]        o_leaf_count
);
    import hcb_pkg::*;

    localparam int NODES     = 2 * SYMBOLS - 1;
    localparam int NODE_W    = $clog2(NODES);
    localparam int SYM_IDX_W = $clog2(SYMBOLS);
    localparam int LEAF_W    = $clog2(SYMBOLS + 1);
    localparam int CMP_W     = NODE_W + 1;

    // count table with per-entry valid bits
    logic [COUNT_BITS-1:0] r_cnt_mem [SYMBOLS];
    logic [SYMBOLS-1:0]    r_cnt_vld;
    logic [COUNT_BITS-1:0] r_cnt_rd;
    logic                  r_cnt_rd_vld;

    // code and length tables with per-entry valid bits
    logic [CODE_W-1:0]     r_code_mem [SYMBOLS];
    logic [LEN_W-1:0]      r_len_mem  [SYMBOLS];
    logic [SYMBOLS-1:0]    r_code_vld;
    logic [CODE_W-1:0]     r_code_rd;
    logic [LEN_W-1:0]      r_len_rd;
    logic                  r_code_rd_vld;

    // node, children and path memories
    t_node                 r_node_mem [NODES];
    logic [2*NODE_W-1:0]   r_kid_mem  [NODES];
    t_path                 r_path_mem [NODES];
    t_node                 r_node_rd;
    logic [2*NODE_W-1:0]   r_kid_rd;
    t_path                 r_path_rd;

    logic                  node_we;
    logic [NODE_W-1:0]     node_waddr;
    t_node                 node_wdata;
    logic                  path_we;
    logic [NODE_W-1:0]     path_waddr;
    t_path                 path_wdata;

    logic [SYM_IDX_W-1:0]  r_s;
    logic [LEAF_W-1:0]     r_n;
    logic [NODE_W-1:0]     r_total;
    logic [NODE_W-1:0]     r_i;
    logic                  r_pipe_vld;
    logic [NODE_W-1:0]     r_pipe_idx;
    logic                  r_have;
    logic [WEIGHT_W-1:0]   r_best_w;
    logic [SYM_W-1:0]      r_best_sym;
    logic [NODE_W-1:0]     r_best_idx;
    logic [WEIGHT_W-1:0]   r_f_w;
    logic [SYM_W-1:0]      r_f_sym;
    logic [NODE_W-1:0]     r_f_idx;
    logic                  r_second;
    logic [LEAF_W-1:0]     r_built;
    logic                  r_rd_ok;
    logic [SYM_W-1:0]      r_rd_sym;

    logic                  sym_ok;
    logic                  leaf_hit;
    logic                  scan_issue;
    logic                  better;
    logic [LEN_W-1:0]      walk_len;
    logic [CODE_W-1:0]     walk_base;
    logic [NODE_W-1:0]     kid_l;
    logic [NODE_W-1:0]     kid_r;

    assign sym_ok     = ({1'b0, i_symbol} < (SYM_W + 1)'(SYMBOLS));
    assign leaf_hit   = r_cnt_rd_vld && (r_cnt_rd != '0);
    assign scan_issue = i_cmd.scan_step && (r_i < r_total);
    assign better     = r_node_rd.alive && (!r_have || (r_node_rd.weight < r_best_w) ||
                        ((r_node_rd.weight == r_best_w) && (r_node_rd.sym > r_best_sym)));
    assign walk_len   = (r_path_rd.len < LEN_MAX) ? r_path_rd.len + 1'b1 : LEN_MAX;
    assign walk_base  = {r_path_rd.code[CODE_W-2:0], 1'b0};
    assign kid_l      = r_kid_rd[NODE_W-1:0];
    assign kid_r      = r_kid_rd[2*NODE_W-1:NODE_W];

    always_comb begin
        o_sts.few        = (r_n < LEAF_W'(2));
        o_sts.leaf_last  = (r_s == SYM_IDX_W'(SYMBOLS - 1));
        o_sts.scan_done  = !(r_i < r_total) && !r_pipe_vld;
        o_sts.second     = r_second;
        o_sts.merge_last = (CMP_W'(r_total) + 1'b1) == ((CMP_W'(r_n) << 1) - 1'b1);
        o_sts.walk_last  = (CMP_W'(r_i) == CMP_W'(r_n));
        o_sts.emit_last  = (CMP_W'(r_i) + 1'b1) == CMP_W'(r_n);
    end

    // node memory write port
    always_comb begin
        node_we    = 1'b0;
        node_waddr = r_total;
        node_wdata = '{alive: 1'b1, sym: r_f_sym, weight: r_f_w + r_best_w};
        if (i_cmd.leaf_wr && leaf_hit) begin
            node_we    = 1'b1;
            node_waddr = NODE_W'(r_n);
            node_wdata = '{alive: 1'b1, sym: SYM_W'(r_s), weight: WEIGHT_W'(r_cnt_rd)};
        end else if (i_cmd.take) begin
            node_we    = 1'b1;
            node_waddr = r_best_idx;
            node_wdata = '{alive: 1'b0, sym: r_best_sym, weight: r_best_w};
        end else if (i_cmd.merge) begin
            node_we    = 1'b1;
        end
    end

    // path memory write port
    always_comb begin
        path_we    = 1'b0;
        path_waddr = r_total - 1'b1;
        path_wdata = '0;
        if (i_cmd.walk_init) begin
            path_we    = 1'b1;
        end else if (i_cmd.walk_l) begin
            path_we    = 1'b1;
            path_waddr = kid_l;
            path_wdata = '{len: walk_len, code: walk_base};
        end else if (i_cmd.walk_r) begin
            path_we    = 1'b1;
            path_waddr = kid_r;
            path_wdata = '{len: walk_len, code: walk_base | CODE_W'(1)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && sym_ok) begin
            r_cnt_mem[i_symbol[SYM_IDX_W-1:0]] <= i_count;
        end
        r_cnt_rd <= r_cnt_mem[r_s];

        if (i_cmd.emit_wr) begin
            r_code_mem[r_node_rd.sym[SYM_IDX_W-1:0]] <= r_path_rd.code;
            r_len_mem[r_node_rd.sym[SYM_IDX_W-1:0]]  <= r_path_rd.len;
        end
        r_code_rd <= r_code_mem[i_symbol[SYM_IDX_W-1:0]];
        r_len_rd  <= r_len_mem[i_symbol[SYM_IDX_W-1:0]];

        if (node_we) begin
            r_node_mem[node_waddr] <= node_wdata;
        end
        r_node_rd <= r_node_mem[r_i];

        if (i_cmd.merge) begin
            r_kid_mem[r_total] <= {r_best_idx, r_f_idx};
        end
        r_kid_rd <= r_kid_mem[r_i];

        if (path_we) begin
            r_path_mem[path_waddr] <= path_wdata;
        end
        r_path_rd <= r_path_mem[r_i];

        r_pipe_idx <= r_i;
        if (i_cmd.rd_issue) begin
            r_rd_ok  <= sym_ok;
            r_rd_sym <= i_symbol;
        end
        if (i_cmd.take && !r_second) begin
            r_f_w   <= r_best_w;
            r_f_sym <= r_best_sym;
            r_f_idx <= r_best_idx;
        end
        if (r_pipe_vld && better) begin
            r_best_w   <= r_node_rd.weight;
            r_best_sym <= r_node_rd.sym;
            r_best_idx <= r_pipe_idx;
        end
        if (i_cmd.rd_out) begin
            o_sym_out     <= r_rd_sym;
            o_code_length <= (r_rd_ok && r_code_rd_vld) ? r_len_rd : '0;
            o_code_bits   <= (r_rd_ok && r_code_rd_vld) ? r_code_rd : '0;
            o_leaf_count  <= LEAFO_W'(r_built);
        end else if (i_cmd.finish) begin
            o_sym_out     <= '0;
            o_code_length <= '0;
            o_code_bits   <= '0;
            o_leaf_count  <= LEAFO_W'(r_n);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_vld     <= '0;
            r_cnt_rd_vld  <= 1'b0;
            r_code_vld    <= '0;
            r_code_rd_vld <= 1'b0;
            r_s           <= '0;
            r_n           <= '0;
            r_total       <= '0;
            r_i           <= '0;
            r_pipe_vld    <= 1'b0;
            r_have        <= 1'b0;
            r_second      <= 1'b0;
            r_built       <= '0;
            o_strobe      <= 1'b0;
        end else begin
            r_cnt_rd_vld  <= r_cnt_vld[r_s];
            r_code_rd_vld <= r_code_vld[i_symbol[SYM_IDX_W-1:0]];
            o_strobe      <= i_cmd.rd_out || i_cmd.finish;
            r_pipe_vld    <= scan_issue;
            if (i_cmd.load && sym_ok) begin
                r_cnt_vld[i_symbol[SYM_IDX_W-1:0]] <= 1'b1;
            end
            if (i_cmd.build_init) begin
                r_code_vld <= '0;
                r_s        <= '0;
                r_n        <= '0;
                r_second   <= 1'b0;
            end
            if (i_cmd.leaf_wr) begin
                r_s <= r_s + 1'b1;
                if (leaf_hit) begin
                    r_n <= r_n + 1'b1;
                end
            end
            if (i_cmd.leaf_end) begin
                r_total <= NODE_W'(r_n);
            end
            // restart the lowest-node search
            if (i_cmd.leaf_end || i_cmd.take || i_cmd.merge) begin
                r_i    <= '0;
                r_have <= 1'b0;
            end
            if (scan_issue) begin
                r_i <= r_i + 1'b1;
            end
            if (r_pipe_vld && better) begin
                r_have <= 1'b1;
            end
            if (i_cmd.take) begin
                r_second <= !r_second;
            end
            if (i_cmd.merge) begin
                r_total <= r_total + 1'b1;
            end
            if (i_cmd.walk_init) begin
                r_i <= r_total - 1'b1;
            end
            if (i_cmd.walk_r) begin
                r_i <= o_sts.walk_last ? '0 : r_i - 1'b1;
            end
            if (i_cmd.emit_wr) begin
                r_i <= r_i + 1'b1;
                r_code_vld[r_node_rd.sym[SYM_IDX_W-1:0]] <= 1'b1;
            end
            if (i_cmd.finish) begin
                r_built <= r_n;
            end
        end
    end
endmodule
`default_nettype wire

### rtl/huffman_code_builder.sv
// Top level of the Huffman code builder: sequencer plus datapath
//
// Usage: drive i_op, i_symbol and i_count with start high; the word is
// taken at a rising edge where start is high and busy is low.
//   op load  : store i_count for i_symbol. No result; busy stays low, so
//              loads may follow back to back.
//   op read  : one result word, registered out of the read state (busy
//              meanwhile): symbol, code length, right-aligned code, leaf count.
//   op build : rebuild every code from the stored counts. Busy throughout.
//              Steps: a pass over every symbol to gather leaves, then per
//              merge two linear searches through the single read port of
//              the node memory plus the take and merge steps, then a tree
//              walk over the internal nodes and a pass writing each leaf's
//              code. The node-memory search dominates the cost. One result
//              word (leaf count) ends it.
//   op three : ignored.
// Results appear on the o_ ports for exactly one cycle with o_strobe high;
// the receiver cannot stall, so it must take every word as it comes.
// Reset clears counts, codes and the leaf count at once (valid bits); no
// clearing pass is needed.
`default_nettype none
module huffman_code_builder #(
    parameter int SYMBOLS    = 256,
    parameter int COUNT_BITS = 31
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [hcb_pkg::OP_W-1:0]  i_op,
    input  wire logic [hcb_pkg::SYM_W-1:0] i_symbol,
    input  wire logic [30:0]               i_count,
    output logic                           o_strobe,
    output logic [hcb_pkg::SYM_W-1:0]      o_sym_out,
    output logic [hcb_pkg::LEN_W-1:0]      o_code_length,
    output logic [hcb_pkg::CODE_W-1:0]     o_code_bits,
    output logic [hcb_pkg::LEAFO_W-1:0]    o_leaf_count
);
    import hcb_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencer: decodes the word and steps through the build phases
    hcb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_op    (i_op),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    // datapath: count, node and code stores; keep only the low count bits
    hcb_datapath #(
        .SYMBOLS    (SYMBOLS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_symbol      (i_symbol),
        .i_count       (i_count[COUNT_BITS-1:0]),
        .o_strobe      (o_strobe),
        .o_sym_out     (o_sym_out),
        .o_code_length (o_code_length),
        .o_code_bits   (o_code_bits),
        .o_leaf_count  (o_leaf_count)
    );
endmodule
`default_nettype wire

### dv/tb_huffman_code_builder.sv
// Self-checking testbench for the Huffman code builder
`timescale 1ns / 100ps
`default_nettype none
module tb_huffman_code_builder;
    import hcb_pkg::*;

    localparam int NSYM     = 256;
    localparam int NNODE    = 2 * NSYM - 1;
    localparam int N_ITEMS  = 1350;
    // A full-alphabet build runs long with nothing taken; STALL_LIMIT
    // leaves ample room for it before calling the run hung.
    localparam int STALL_LIMIT = 2_000_000;
    localparam int DRAIN_CYCLES = 20;

    // Expected contents of one result word
    typedef struct {
        logic [SYM_W-1:0]   sym;
        logic [LEN_W-1:0]   len;
        logic [CODE_W-1:0]  code;
        logic [LEAFO_W-1:0] leaves;
    } t_code_word;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [OP_W-1:0]      i_op;
    logic [SYM_W-1:0]     i_symbol;
    logic [30:0]          i_count;
    logic                 o_strobe;
    logic [SYM_W-1:0]     o_sym_out;
    logic [LEN_W-1:0]     o_code_length;
    logic [CODE_W-1:0]    o_code_bits;
    logic [LEAFO_W-1:0]   o_leaf_count;

    huffman_code_builder u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_op         (i_op),
        .i_symbol     (i_symbol),
        .i_count      (i_count),
        .o_strobe     (o_strobe),
        .o_sym_out    (o_sym_out),
        .o_code_length(o_code_length),
        .o_code_bits  (o_code_bits),
        .o_leaf_count (o_leaf_count)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // ---------------------------------------------------------------
    // Shadow of the block: count table, code tables and leaf count
    // ---------------------------------------------------------------
    logic [30:0]          sh_count [NSYM];
    logic [CODE_W-1:0]    sh_code  [NSYM];
    logic [LEN_W-1:0]     sh_len   [NSYM];
    logic [LEAFO_W-1:0]   sh_leaves;

    // Node workspace for the shadow build
    logic [WEIGHT_W-1:0]  nd_weight [NNODE];
    logic [SYM_W-1:0]     nd_sym    [NNODE];
    int                   nd_left   [NNODE];
    int                   nd_right  [NNODE];
    bit                   nd_alive  [NNODE];
    logic [CODE_W-1:0]    nd_path   [NNODE];
    logic [LEN_W-1:0]     nd_depth  [NNODE];

    t_code_word pending_codes[$];
    int         n_errors;
    int         n_sent;
    bit         no_gaps;
    int         quiet_cycles;

    // Queue one expected word at the tail
    function automatic void add_expected(t_code_word w);
        pending_codes.insert(pending_codes.size(), w);
    endfunction

    // Rebuild the shadow code table from the shadow counts
    function automatic void rebuild_code_table();
        int n;
        int total;
        int best;
        int pick [2];
        logic [LEN_W-1:0]  depth;
        logic [CODE_W-1:0] base;
        n = 0;
        for (int s = 0; s < NSYM; s++) begin
            if (sh_count[s] != '0) begin
                nd_weight[n] = WEIGHT_W'(sh_count[s]);
                nd_sym[n]    = SYM_W'(s);
                nd_alive[n]  = 1'b1;
                n++;
            end
        end
        for (int i = n; i < NNODE; i++)
            nd_alive[i] = 1'b0;
        total = n;
        // merge the two lowest: smaller weight, then larger first symbol
        while (n >= 2 && total < 2 * n - 1) begin
            for (int k = 0; k < 2; k++) begin
                best = -1;
                for (int i = 0; i < total; i++) begin
                    if (nd_alive[i] && (best < 0 || nd_weight[i] < nd_weight[best] ||
                        (nd_weight[i] == nd_weight[best] && nd_sym[i] > nd_sym[best])))
                        best = i;
                end
                nd_alive[best] = 1'b0;
                pick[k] = best;
            end
            nd_weight[total] = nd_weight[pick[0]] + nd_weight[pick[1]];
            nd_sym[total]    = nd_sym[pick[0]];
            nd_left[total]   = pick[0];
            nd_right[total]  = pick[1];
            nd_alive[total]  = 1'b1;
            total++;
        end
        for (int s = 0; s < NSYM; s++) begin
            sh_code[s] = '0;
            sh_len[s]  = '0;
        end
        sh_leaves = LEAFO_W'(n);
        if (n < 2)
            return;
        // walk down from the root, left child gets bit 0
        nd_path[total-1]  = '0;
        nd_depth[total-1] = '0;
        for (int i = total - 1; i >= n; i--) begin
            depth = (nd_depth[i] < LEN_MAX) ? nd_depth[i] + 1'b1 : LEN_MAX;
            base  = nd_path[i] << 1;
            nd_path[nd_left[i]]   = base;
            nd_depth[nd_left[i]]  = depth;
            nd_path[nd_right[i]]  = base | 64'd1;
            nd_depth[nd_right[i]] = depth;
        end
        for (int i = 0; i < n; i++) begin
            sh_code[nd_sym[i]] = nd_path[i];
            sh_len[nd_sym[i]]  = nd_depth[i];
        end
    endfunction

    // Apply one taken word to the shadow and queue what it should return
    function automatic void predict_word(logic [OP_W-1:0] op, logic [SYM_W-1:0] sym,
                                         logic [30:0] cnt);
        t_code_word w;
        case (op)
            OP_LOAD: begin
                sh_count[sym] = cnt;
            end
            OP_BUILD: begin
                rebuild_code_table();
                w.sym = '0; w.len = '0; w.code = '0; w.leaves = sh_leaves;
                add_expected(w);
            end
            OP_READ: begin
                w.sym = sym; w.len = sh_len[sym]; w.code = sh_code[sym];
                w.leaves = sh_leaves;
                add_expected(w);
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        n_errors++;
    endtask

    // ---------------------------------------------------------------
    // Result checker: every strobe must match the oldest expectation
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_code_word w;
        if (i_rst_n && o_strobe) begin
            if (pending_codes.size() == 0) begin
                report_mismatch("unexpected word", {56'd0, o_sym_out}, 64'd0);
            end else begin
                w = pending_codes.pop_front();
                if (o_sym_out !== w.sym)
                    report_mismatch("sym_out", 64'(o_sym_out), 64'(w.sym));
                if (o_code_length !== w.len)
                    report_mismatch("code_length", 64'(o_code_length), 64'(w.len));
                if (o_code_bits !== w.code)
                    report_mismatch("code_bits", o_code_bits, w.code);
                if (o_leaf_count !== w.leaves)
                    report_mismatch("leaf_count", 64'(o_leaf_count), 64'(w.leaves));
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || o_strobe || (start && !busy)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // Sender
    // ---------------------------------------------------------------
    // Offer one word and hold it until taken. Start is left high after the
    // taking edge; the next call either drops it for a gap or reuses it.
    task automatic send_word(logic [OP_W-1:0] op, logic [SYM_W-1:0] sym, logic [30:0] cnt);
        int gap;
        gap = (!no_gaps && $urandom_range(99) < 33) ? $urandom_range(1, 5) : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            start    <= 1'b0;
            i_op     <= OP_W'($urandom);
            i_symbol <= SYM_W'($urandom);
            i_count  <= 31'($urandom);
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start    <= 1'b1;
        i_op     <= op;
        i_symbol <= sym;
        i_count  <= cnt;
        forever begin
            @(posedge i_clk);
            if (!busy)
                break;
        end
        predict_word(op, sym, cnt);
        n_sent++;
    endtask

    // Drop start and hold off until every expected word has come back
    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_codes.size() != 0)
            @(posedge i_clk);
    endtask

    // Zero every nonzero count so the next build starts from nothing
    task automatic clear_counts();
        for (int s = 0; s < NSYM; s++)
            if (sh_count[s] != '0)
                send_word(OP_LOAD, SYM_W'(s), '0);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // Codes straight out of reset are empty; so are they after a build with no leaves or a single leaf
    task automatic test_empty_and_single();
        send_word(OP_READ, 8'd0, '0);
        send_word(OP_READ, 8'd255, '0);
        send_word(OP_BUILD, 8'd77, 31'h7fff_ffff);
        send_word(OP_READ, 8'd128, '0);
        send_word(OP_LOAD, 8'd255, 31'h7fff_ffff);
        send_word(OP_BUILD, '0, '0);
        send_word(OP_READ, 8'd255, '0);
        send_word(OP_NONE, 8'd255, 31'h7fff_ffff);
    endtask

    // Field extremes, ties on weight and 40-bit weight sums
    task automatic test_extremes();
        send_word(OP_LOAD, 8'd0, 31'h7fff_ffff);
        send_word(OP_LOAD, 8'd1, 31'h7fff_ffff);
        send_word(OP_LOAD, 8'd254, 31'd1);
        send_word(OP_LOAD, 8'd255, 31'd1);
        send_word(OP_LOAD, 8'd128, 31'h7fff_fffe);
        send_word(OP_NONE, 8'd0, '0);
        send_word(OP_BUILD, '0, '0);
        send_word(OP_READ, 8'd0, '0);
        send_word(OP_READ, 8'd1, '0);
        send_word(OP_READ, 8'd128, '0);
        send_word(OP_READ, 8'd254, '0);
        send_word(OP_READ, 8'd255, '0);
        send_word(OP_READ, 8'd5, '0);
        drain_results();
    endtask

    // Fibonacci counts give the deepest tree the count width allows
    task automatic test_deep_tree();
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        int          s;
        clear_counts();
        a = 1; b = 1; s = 3;
        while (b < 32'h8000_0000 && s < NSYM) begin
            send_word(OP_LOAD, SYM_W'(s), 31'(b));
            c = a + b; a = b; b = c;
            s += 5;
        end
        send_word(OP_BUILD, '0, '0);
        for (int k = 3; k < s; k += 5)
            send_word(OP_READ, SYM_W'(k), '0);
    endtask

    // One build over all 256 symbols: the slowest case, done once only
    task automatic test_full_alphabet();
        no_gaps = 1'b1;
        for (int s = 0; s < NSYM; s++)
            send_word(OP_LOAD, SYM_W'(s), 31'($urandom_range(1, 64)));
        send_word(OP_BUILD, '0, '0);
        for (int k = 0; k < 12; k++)
            send_word(OP_READ, SYM_W'($urandom), '0);
        no_gaps = 1'b0;
        drain_results();
    endtask

    // Random load / build / read phases with small alphabets
    task automatic test_random_phases();
        int              nleaf;
        int              nread;
        logic [SYM_W-1:0] loaded[$];
        logic [SYM_W-1:0] sym;
        logic [30:0]     cnt;
        while (n_sent < N_ITEMS) begin
            no_gaps = ($urandom_range(9) == 0);
            clear_counts();
            loaded.delete();
            nleaf = $urandom_range(0, 24);
            for (int k = 0; k < nleaf; k++) begin
                sym = SYM_W'($urandom);
                case ($urandom_range(3))
                    0: cnt = 31'($urandom);
                    1: cnt = 31'($urandom_range(1, 4));
                    2: cnt = 31'h7fff_ffff - 31'($urandom_range(0, 3));
                    default: cnt = 31'($urandom_range(1, 1000));
                endcase
                send_word(OP_LOAD, sym, cnt);
                loaded.insert(loaded.size(), sym);
                // noise: op three, or a zero load that removes a leaf
                if ($urandom_range(9) == 0)
                    send_word(OP_NONE, SYM_W'($urandom), 31'($urandom));
                if ($urandom_range(19) == 0)
                    send_word(OP_LOAD, SYM_W'($urandom), '0);
            end
            if ($urandom_range(7) != 0)
                send_word(OP_BUILD, SYM_W'($urandom), 31'($urandom));
            nread = $urandom_range(2, 12);
            for (int k = 0; k < nread; k++) begin
                if (loaded.size() != 0 && $urandom_range(3) != 0)
                    sym = loaded[$urandom_range(loaded.size() - 1)];
                else
                    sym = SYM_W'($urandom);
                send_word(OP_READ, sym, 31'($urandom));
            end
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        for (int s = 0; s < NSYM; s++) begin
            sh_count[s] = '0;
            sh_code[s]  = '0;
            sh_len[s]   = '0;
        end
        sh_leaves    = '0;
        n_errors     = 0;
        n_sent       = 0;
        no_gaps      = 1'b0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_op         = OP_NONE;
        i_symbol     = '0;
        i_count      = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_and_single();
        test_extremes();
        test_deep_tree();
        test_full_alphabet();
        test_random_phases();

        // drop start, then wait for the tail of results
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0 && pending_codes.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

### files.f
+incdir+rtl
rtl/hcb_pkg.sv
rtl/hcb_ctrl.sv
rtl/hcb_datapath.sv
rtl/huffman_code_builder.sv
dv/tb_huffman_code_builder.sv
